[src/ecd_pkg.sv]
// Shared types, constants and helpers of the elliptic cylinder distance unit.
package ecd_pkg;

  // Quaternion components are signed Q2.14, four packed in one register
  localparam int QUAT_W = 16;
  localparam int QUAT_FRAC = 14;
  localparam logic [63:0] QUAT_RESET = 64'd16384;

  // Rotation matrix entries after rounding back to Q.14
  localparam int MAT_W = 21;
  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

  // Configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_QUAT = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_LENGTH = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_RADIUS_Y = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_RADIUS_Z = 3'd4;

  // Region codes of the result
  typedef enum logic [2:0] {
    RGN_BEFORE_IN  = 3'd0,
    RGN_BEFORE_OUT = 3'd1,
    RGN_AFTER_IN   = 3'd2,
    RGN_AFTER_OUT  = 3'd3,
    RGN_BESIDE     = 3'd4
  } region_t;

  // Shift right by 14, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] v);
    logic signed [63:0] bias;
    bias = v[63] ? 64'sd8191 : 64'sd8192;
    return (v + bias) >>> QUAT_FRAC;
  endfunction

endpackage

[src/ecd_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module ecd_sqrt_pipe #(
  parameter int IW = 8,
  parameter int TAGW = 1,
  localparam int EIW = IW + (IW % 2),
  localparam int RW = EIW / 2,
  localparam int RMW = RW + 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IW-1:0]   in_val,
  input  logic [TAGW-1:0] in_tag,
  output logic            out_valid,
  output logic [RW:0]     out_root,
  output logic [TAGW-1:0] out_tag
);

  logic [EIW-1:0]  sh_r    [RW];
  logic [EIW-1:0]  sh_nxt  [RW];
  logic [RMW-1:0]  rem_r   [RW];
  logic [RMW-1:0]  rem_nxt [RW];
  logic [RW-1:0]   root_r  [RW];
  logic [RW-1:0]   root_nxt[RW];
  logic [TAGW-1:0] tag_r   [RW];
  logic [TAGW-1:0] tag_nxt [RW];
  logic            vld_r   [RW];
  logic            vld_nxt [RW];

  logic            out_valid_r;
  logic [RW:0]     out_root_r;
  logic [TAGW-1:0] out_tag_r;

  // One digit pair per stage: trial subtract of (root<<2)|1
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [EIW-1:0] sh_p;
    logic [RMW-1:0] rem_p;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic [RW-1:0]  root_p;
    logic           ge;

    if (k == 0) begin : g_first
      assign sh_p = EIW'(in_val);
      assign rem_p = '0;
      assign root_p = '0;
      assign vld_nxt[k] = in_valid;
      assign tag_nxt[k] = in_tag;
    end else begin : g_next
      assign sh_p = sh_r[k-1];
      assign rem_p = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign vld_nxt[k] = vld_r[k-1];
      assign tag_nxt[k] = tag_r[k-1];
    end

    assign rem_sh = {rem_p[RMW-3:0], sh_p[EIW-1 -: 2]};
    assign trial = {root_p, 2'b01};
    assign ge = (rem_sh >= trial);
    assign rem_nxt[k] = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt[k] = {root_p[RW-2:0], ge};
    assign sh_nxt[k] = sh_p << 2;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RW; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < RW; i++) vld_r[i] <= vld_nxt[i];
      out_valid_r <= vld_r[RW-1];
    end
  end

  // Stage data; last register rounds up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RW; i++) begin
        sh_r[i] <= sh_nxt[i];
        rem_r[i] <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        tag_r[i] <= tag_nxt[i];
      end
      out_root_r <= {1'b0, root_r[RW-1]}
                    + (RW+1)'(rem_r[RW-1] > RMW'(root_r[RW-1]));
      out_tag_r <= tag_r[RW-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_root = out_root_r;
  assign out_tag = out_tag_r;

endmodule

[src/ecd_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
module ecd_div_pipe #(
  parameter int NUMW = 16,
  parameter int DENW = 8,
  parameter int QW = 8,
  parameter int TAGW = 1,
  localparam int CW = (NUMW > DENW + QW) ? NUMW : DENW + QW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NUMW-1:0] in_num,
  input  logic [DENW-1:0] in_den,
  input  logic [TAGW-1:0] in_tag,
  output logic            out_valid,
  output logic [QW-1:0]   out_quot,
  output logic [TAGW-1:0] out_tag
);

  logic [NUMW-1:0] rem_r   [QW];
  logic [NUMW-1:0] rem_nxt [QW];
  logic [DENW-1:0] den_r   [QW];
  logic [DENW-1:0] den_nxt [QW];
  logic [QW-1:0]   q_r     [QW];
  logic [QW-1:0]   q_nxt   [QW];
  logic [TAGW-1:0] tag_r   [QW];
  logic [TAGW-1:0] tag_nxt [QW];
  logic            vld_r   [QW];
  logic            vld_nxt [QW];

  // Quotient bits from the top: subtract den<<b where it fits
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NUMW-1:0] rem_p;
    logic [DENW-1:0] den_p;
    logic [QW-1:0]   q_p;
    logic [CW-1:0]   rem_e;
    logic [CW-1:0]   dsh;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_p = in_num;
      assign den_p = in_den;
      assign q_p = '0;
      assign vld_nxt[k] = in_valid;
      assign tag_nxt[k] = in_tag;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign q_p = q_r[k-1];
      assign vld_nxt[k] = vld_r[k-1];
      assign tag_nxt[k] = tag_r[k-1];
    end

    assign rem_e = CW'(rem_p);
    assign dsh = CW'(den_p) << B;
    assign ge = (rem_e >= dsh);
    assign rem_nxt[k] = ge ? NUMW'(rem_e - dsh) : rem_p;
    assign den_nxt[k] = den_p;
    assign q_nxt[k] = {q_p[QW-2:0], ge};
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < QW; i++) vld_r[i] <= vld_nxt[i];
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_nxt[i];
        q_r[i] <= q_nxt[i];
        tag_r[i] <= tag_nxt[i];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot = q_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

[src/elliptic_cylinder_distance.sv]
// Top level: approximate signed distance from a point to an elliptic cylinder.
// Path from accept to out_valid: input stages, the axis square root, the radius divider, further
// stages, the corner square root and the output register; roots and quotient resolve one bit per stage.
// Throughput: one point per cycle; the whole pipeline holds while the result waits.
// Reset: synchronous, active low; clears valid bits and sets the registers to
// zero origin, identity rotation and zero length and radii.
module elliptic_cylinder_distance #(
  parameter int COORD_WIDTH = 16,
  localparam int CFG_DW = (3 * COORD_WIDTH > 64) ? 3 * COORD_WIDTH : 64,
  localparam int DIST_WIDTH = COORD_WIDTH + 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DIST_WIDTH-1:0]  out_distance,
  output logic [2:0]                    out_region,
  input  logic                          cfg_wr_en,
  input  logic [ecd_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]             cfg_wdata
);

  localparam int W = COORD_WIDTH;
  localparam int DW = DIST_WIDTH;
  localparam int MW = ecd_pkg::MAT_W;
  localparam int DFW = W + 1;
  localparam int PRW = MW + DFW;
  localparam int AW = PRW + 2;
  localparam int TPW = (W + 10 < 32) ? W + 10 : 32;
  localparam int ABW = TPW - 1;
  localparam int SQW = 2 * ABW + 1;
  localparam int ADW = TPW + 1;
  localparam int NW = W + ABW;
  localparam int NUMW = W + TPW;
  localparam int QW = W + 1;
  localparam int RADW = W + 3;
  localparam int EW = (TPW + 2 > W + 4) ? TPW + 2 : W + 4;
  localparam int SQ2W = 2 * EW - 1;
  localparam int FW = EW + 2;
  localparam int TAG1W = NW + TPW + 2;
  localparam int TAG2W = ADW + TPW + 2;
  localparam int TAG3W = EW + 4;
  localparam longint DMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam longint DMIN = -DMAX - 64'sd1;

  logic en;

  // Configuration registers
  logic [3*W-1:0] origin_r;
  logic [63:0]    quat_r;
  logic [W-1:0]   len_r;
  logic [W-1:0]   ry_r;
  logic [W-1:0]   rz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      quat_r <= ecd_pkg::QUAT_RESET;
      len_r <= '0;
      ry_r <= '0;
      rz_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ecd_pkg::CFG_ORIGIN:   origin_r <= cfg_wdata[3*W-1:0];
        ecd_pkg::CFG_QUAT:     quat_r <= cfg_wdata[63:0];
        ecd_pkg::CFG_LENGTH:   len_r <= cfg_wdata[W-1:0];
        ecd_pkg::CFG_RADIUS_Y: ry_r <= cfg_wdata[W-1:0];
        ecd_pkg::CFG_RADIUS_Z: rz_r <= cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Rotation matrix: quaternion products, then entries rounded to Q.14
  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_xz_r, p_yz_r;
  logic signed [31:0] p_wx_r, p_wy_r, p_wz_r;
  logic signed [63:0] m64 [3][3];
  logic signed [MW-1:0] mat_r [3][3];

  assign qw = {{16{quat_r[15]}}, quat_r[15:0]};
  assign qx = {{16{quat_r[31]}}, quat_r[31:16]};
  assign qy = {{16{quat_r[47]}}, quat_r[47:32]};
  assign qz = {{16{quat_r[63]}}, quat_r[63:48]};

  always_ff @(posedge clk) begin
    p_xx_r <= qx * qx;
    p_yy_r <= qy * qy;
    p_zz_r <= qz * qz;
    p_xy_r <= qx * qy;
    p_xz_r <= qx * qz;
    p_yz_r <= qy * qz;
    p_wx_r <= qw * qx;
    p_wy_r <= qw * qy;
    p_wz_r <= qw * qz;
  end

  always_comb begin
    m64[0][0] = ecd_pkg::ONE_Q28 - 64'sd2 * (64'(p_yy_r) + 64'(p_zz_r));
    m64[0][1] = 64'sd2 * (64'(p_xy_r) - 64'(p_wz_r));
    m64[0][2] = 64'sd2 * (64'(p_xz_r) + 64'(p_wy_r));
    m64[1][0] = 64'sd2 * (64'(p_xy_r) + 64'(p_wz_r));
    m64[1][1] = ecd_pkg::ONE_Q28 - 64'sd2 * (64'(p_xx_r) + 64'(p_zz_r));
    m64[1][2] = 64'sd2 * (64'(p_yz_r) - 64'(p_wx_r));
    m64[2][0] = 64'sd2 * (64'(p_xz_r) - 64'(p_wy_r));
    m64[2][1] = 64'sd2 * (64'(p_yz_r) + 64'(p_wx_r));
    m64[2][2] = ecd_pkg::ONE_Q28 - 64'sd2 * (64'(p_xx_r) + 64'(p_yy_r));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        mat_r[i][j] <= MW'(ecd_pkg::rnd_q14(m64[i][j]));
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r, v12_r;
  logic out_valid_r;

  // Pipeline advances whenever the output register is free or being taken
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: input capture
  logic signed [W-1:0] pt1_r [3];
  // Stage 2: offset from origin
  logic signed [DFW-1:0] d2_r [3];
  // Stage 3: matrix products (transposed matrix)
  logic signed [PRW-1:0] pr3_r [3][3];
  // Stage 4: row sums
  logic signed [AW-1:0] acc4_r [3];
  // Stage 5: rounded local coordinates, clamped to +/-(2^31-1), then narrowed to TPW bits
  logic signed [TPW-1:0] tp5_r [3];
  logic signed [63:0] r64 [3];
  logic signed [63:0] c64 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r64[i] = ecd_pkg::rnd_q14(64'(acc4_r[i]));
      if (r64[i] > 64'sd2147483647) c64[i] = 64'sd2147483647;
      else if (r64[i] < -64'sd2147483647) c64[i] = -64'sd2147483647;
      else c64[i] = r64[i];
    end
  end

  // Stage 6: squares of the cross coordinates and radius numerator
  logic [ABW-1:0] aby, abz;
  logic [W-1:0] rdmag;
  logic [2*ABW-1:0] sqy6_r, sqz6_r;
  logic [NW-1:0] nmag6_r;
  logic nneg6_r, zero6_r;
  logic signed [TPW-1:0] tp0_6_r;

  assign aby = tp5_r[1][TPW-1] ? ABW'(-tp5_r[1]) : ABW'(tp5_r[1]);
  assign abz = tp5_r[2][TPW-1] ? ABW'(-tp5_r[2]) : ABW'(tp5_r[2]);
  assign rdmag = (ry_r < rz_r) ? (rz_r - ry_r) : (ry_r - rz_r);

  // Stage 7: sum of squares into the axis-distance root
  logic [SQW-1:0] ssum7_r;
  logic [TAG1W-1:0] tag7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pt1_r[0] <= in_point_x;
      pt1_r[1] <= in_point_y;
      pt1_r[2] <= in_point_z;
      for (int i = 0; i < 3; i++)
        d2_r[i] <= DFW'(pt1_r[i]) - DFW'(signed'(origin_r[i*W +: W]));
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr3_r[i][j] <= PRW'(mat_r[j][i]) * PRW'(d2_r[j]);
      for (int i = 0; i < 3; i++)
        acc4_r[i] <= AW'(pr3_r[i][0]) + AW'(pr3_r[i][1]) + AW'(pr3_r[i][2]);
      for (int i = 0; i < 3; i++)
        tp5_r[i] <= TPW'(c64[i]);
      sqy6_r <= (2*ABW)'(aby) * (2*ABW)'(aby);
      sqz6_r <= (2*ABW)'(abz) * (2*ABW)'(abz);
      nmag6_r <= NW'(rdmag) * NW'(aby);
      nneg6_r <= (ry_r < rz_r);
      zero6_r <= (tp5_r[1] == '0) && (tp5_r[2] == '0);
      tp0_6_r <= tp5_r[0];
      ssum7_r <= SQW'(sqy6_r) + SQW'(sqz6_r);
      tag7_r <= {nmag6_r, nneg6_r, tp0_6_r, zero6_r};
    end
  end

  // Axis distance
  logic s1_valid;
  logic [ADW-1:0] ad1;
  logic [TAG1W-1:0] s1_tag;

  ecd_sqrt_pipe #(.IW(SQW), .TAGW(TAG1W)) u_sqrt_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v7_r),
    .in_val   (ssum7_r),
    .in_tag   (tag7_r),
    .out_valid(s1_valid),
    .out_root (ad1),
    .out_tag  (s1_tag)
  );

  // Stage 8: rounded numerator for the radius division
  logic [NW-1:0] s1_nmag;
  logic s1_nneg, s1_zero;
  logic signed [TPW-1:0] s1_tp0;
  logic [NUMW-1:0] num8_r;
  logic [ADW-1:0] den8_r;
  logic [TAG2W-1:0] tag8_r;

  assign {s1_nmag, s1_nneg, s1_tp0, s1_zero} = s1_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      num8_r <= NUMW'(s1_nmag) + NUMW'(ad1 >> 1);
      den8_r <= ad1;
      tag8_r <= {ad1, s1_nneg, s1_tp0, s1_zero};
    end
  end

  logic dv_valid;
  logic [QW-1:0] quot;
  logic [TAG2W-1:0] dv_tag;

  ecd_div_pipe #(.NUMW(NUMW), .DENW(ADW), .QW(QW), .TAGW(TAG2W)) u_div_radius (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v8_r),
    .in_num   (num8_r),
    .in_den   (den8_r),
    .in_tag   (tag8_r),
    .out_valid(dv_valid),
    .out_quot (quot),
    .out_tag  (dv_tag)
  );

  // Stage 9: elliptic radius
  logic [ADW-1:0] dv_ad;
  logic dv_nneg, dv_zero;
  logic signed [TPW-1:0] dv_tp0;
  logic signed [RADW-1:0] qs;
  logic [W-1:0] rmin;
  logic signed [RADW-1:0] rad9_r;
  logic [ADW-1:0] ad9_r;
  logic signed [TPW-1:0] tp0_9_r;

  assign {dv_ad, dv_nneg, dv_tp0, dv_zero} = dv_tag;
  assign qs = dv_nneg ? -RADW'(quot) : RADW'(quot);
  assign rmin = (ry_r < rz_r) ? ry_r : rz_r;

  // Stage 10: region choice and direct distances
  logic signed [EW-1:0] tp0e, lene, ade, rade, plane, tube, pmid, besd;
  logic pre_start, after, intube;
  ecd_pkg::region_t rgn;
  logic signed [EW-1:0] direct10_r, plane10_r, tube10_r;
  ecd_pkg::region_t rgn10_r;
  logic hyp10_r;

  always_comb begin
    tp0e = EW'(tp0_9_r);
    lene = EW'(len_r);
    ade = EW'(ad9_r);
    rade = EW'(rad9_r);
    pre_start = (tp0e <= 0);
    after = !pre_start && (tp0e >= lene);
    plane = pre_start ? -tp0e : (tp0e - lene);
    tube = ade - rade;
    intube = (ade < rade);
    pmid = (tp0e < lene - tp0e) ? tp0e : (lene - tp0e);
    besd = (tube < pmid) ? tube : pmid;
    if (pre_start) rgn = intube ? ecd_pkg::RGN_BEFORE_IN : ecd_pkg::RGN_BEFORE_OUT;
    else if (after) rgn = intube ? ecd_pkg::RGN_AFTER_IN : ecd_pkg::RGN_AFTER_OUT;
    else rgn = ecd_pkg::RGN_BESIDE;
  end

  // Stage 11: squares for the corner distance; stage 12: their sum
  logic [2*EW-3:0] sqp11_r, sqt11_r;
  logic [TAG3W-1:0] tag11_r;
  logic [SQ2W-1:0] ssum12_r;
  logic [TAG3W-1:0] tag12_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad9_r <= dv_zero ? RADW'(rmin) : (RADW'(rz_r) + qs);
      ad9_r <= dv_ad;
      tp0_9_r <= dv_tp0;
      direct10_r <= (pre_start || after) ? plane : besd;
      plane10_r <= plane;
      tube10_r <= tube;
      rgn10_r <= rgn;
      hyp10_r <= (pre_start || after) && !intube;
      sqp11_r <= (2*EW-2)'(plane10_r[EW-2:0]) * (2*EW-2)'(plane10_r[EW-2:0]);
      sqt11_r <= (2*EW-2)'(tube10_r[EW-2:0]) * (2*EW-2)'(tube10_r[EW-2:0]);
      tag11_r <= {direct10_r, rgn10_r, hyp10_r};
      ssum12_r <= SQ2W'(sqp11_r) + SQ2W'(sqt11_r);
      tag12_r <= tag11_r;
    end
  end

  // Corner distance outside the tube beyond either end
  logic s2_valid;
  logic [EW:0] root2;
  logic [TAG3W-1:0] s2_tag;

  ecd_sqrt_pipe #(.IW(SQ2W), .TAGW(TAG3W)) u_sqrt_corner (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v12_r),
    .in_val   (ssum12_r),
    .in_tag   (tag12_r),
    .out_valid(s2_valid),
    .out_root (root2),
    .out_tag  (s2_tag)
  );

  // Output stage: pick the distance and saturate
  logic signed [EW-1:0] s2_direct;
  logic [2:0] s2_rgn;
  logic s2_hyp;
  logic signed [FW-1:0] dfull;
  logic signed [DW-1:0] dsat;
  logic signed [DW-1:0] out_distance_r;
  logic [2:0] out_region_r;

  assign {s2_direct, s2_rgn, s2_hyp} = s2_tag;

  always_comb begin
    dfull = s2_hyp ? FW'(root2) : FW'(s2_direct);
    if (dfull > FW'(DMAX)) dsat = DW'(DMAX);
    else if (dfull < FW'(DMIN)) dsat = DW'(DMIN);
    else dsat = DW'(dfull);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_distance_r <= dsat;
      out_region_r <= s2_rgn;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= s1_valid;
      v9_r <= dv_valid;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      out_valid_r <= s2_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_region = out_region_r;

endmodule
